@@ design/gsps_pkg.sv @@
// ============================================================================
// gsps_pkg
// Shared constants, codes and types of the gapped sequence pair scorer.
// ============================================================================
package gsps_pkg;

    localparam int MAX_LEN   = 64;
    localparam int MAX_GAPS  = 8;
    localparam int ALPHABET  = 256;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int GCNT_W    = $clog2(MAX_GAPS + 1);
    localparam int GIDX_W    = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;
    localparam int CHAR_W    = $clog2(ALPHABET);
    localparam int TAB_AW    = 2 * CHAR_W;
    localparam int ACC_W     = 24;
    localparam int PROD_W    = ACC_W + 16;
    localparam logic signed [15:0] ONE_Q88 = 16'sd256;

    typedef enum logic [2:0] {
        MODE_TABLE_WR = 3'd0,
        MODE_CLEAR    = 3'd1,
        MODE_APP_CHAR = 3'd2,
        MODE_APP_GAP  = 3'd3,
        MODE_COMPUTE  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NOGAP = 2'd2,
        ST_OVF   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_GAP_PEN  = 3'd0,
        CFG_V_OFF    = 3'd1,
        CFG_J_OFF    = 3'd2,
        CFG_SCALE    = 3'd3,
        CFG_USE_MAT  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SEL_SCALED = 2'd0,
        SEL_ZERO   = 2'd1,
        SEL_MIN    = 2'd2
    } t_res_sel;

    // One column in flight alongside the sequence memory read data.
    typedef struct packed {
        logic valid;
        logic is_gap;
    } t_col_req;

    // Request from the sequencer to the output stage.
    typedef struct packed {
        logic                    go;
        t_res_sel                sel;
        t_status                 status;
        logic signed [ACC_W-1:0] best;
    } t_res_req;

endpackage

@@ design/gsps_table.sv @@
// ============================================================================
// gsps_table
// Substitution table memory and per-column cost selection.
// ============================================================================
module gsps_table
    import gsps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [TAB_AW-1:0]        i_wr_addr,
    input  logic signed [15:0]       i_wr_data,
    input  t_col_req                 i_col,
    input  logic [CHAR_W-1:0]        i_char_a,
    input  logic [CHAR_W-1:0]        i_char_b,
    input  logic                     i_use_matrix,
    input  logic signed [15:0]       i_gap_penalty,
    output logic                     o_cost_valid,
    output logic signed [15:0]       o_cost
);

    logic signed [15:0] r_mem [2**TAB_AW];
    logic signed [15:0] r_tab;
    logic               r_valid;
    logic               r_gap;
    logic               r_mismatch;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_tab      <= r_mem[{i_char_a, i_char_b}];
        r_gap      <= i_col.is_gap;
        r_mismatch <= (i_char_a != i_char_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_col.valid;
        end
    end

    assign o_cost_valid = r_valid;

    always_comb begin
        if (r_gap) begin
            o_cost = i_gap_penalty;
        end else if (i_use_matrix) begin
            o_cost = r_tab;
        end else begin
            o_cost = r_mismatch ? ONE_Q88 : 16'sd0;
        end
    end

endmodule

@@ design/gsps_score_out.sv @@
// ============================================================================
// gsps_score_out
// Scales the best score, rounds it, and holds the result for the receiver.
// ============================================================================
module gsps_score_out
    import gsps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_res_req           i_req,
    input  logic signed [15:0] i_scale,
    output logic               o_free,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [31:0]        m_axis_tdata,
    output logic [7:0]         m_axis_tuser
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] w_round;
    t_res_sel                 r_sel;
    t_status                  r_stat;
    logic                     r_pend;
    logic                     r_valid;
    logic [31:0]              r_score;
    t_status                  r_ostat;

    // Product stays well inside 32 bits after the shift, so no clipping.
    assign w_round = (r_prod + PROD_W'(128)) >>> 8;

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_prod <= PROD_W'(i_req.best) * PROD_W'(i_scale);
            r_sel  <= i_req.sel;
            r_stat <= i_req.status;
        end
        if (r_pend) begin
            r_ostat <= r_stat;
            unique case (r_sel)
                SEL_ZERO: r_score <= 32'h0000_0000;
                SEL_MIN:  r_score <= 32'h8000_0000;
                default:  r_score <= w_round[31:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_pend <= i_req.go;
            if (r_pend) begin
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_free        = !r_pend && (!r_valid || m_axis_tready);
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_score;
    assign m_axis_tuser  = {6'd0, r_ostat};

endmodule

@@ design/gapped_sequence_pair_score_top.sv @@
// ============================================================================
// gapped_sequence_pair_score_top
// Gapped substitution score of two stored sequences, best over gap positions.
// ============================================================================
// Usage: requests arrive on the s_axis stream. tuser[2:0] selects the mode
// (table write, clear pair, append character, append gap, compute) and
// tuser[3] selects the sequence for a character append. Load requests
// produce no result. A compute request produces exactly one result on
// m_axis: tdata is the scaled best score (signed Q24.8) and tuser[1:0]
// is the status code.
// A compute request walks every stored gap position. Each position passes
// through a setup step, a run step that issues the window columns through
// the sequence memories and the substitution table, a drain step and a
// compare step. An empty window or an empty gap list skips the walk and
// goes straight to the result.
// Configuration writes on i_cfg_* take effect at once. The user must make
// them only while the block is idle; the block does not enforce this. Reset
// (synchronous, active low) empties both sequences and the gap list, clears
// the overflow flag and loads register defaults; the table and the sequence
// memories keep their contents and need no clearing.
// A result waits in the output register while the receiver stalls; new load
// requests are still taken, and a later compute holds at its end until the
// output register is free.
// ============================================================================
module gapped_sequence_pair_score_top
    import gsps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row_char[7:0], col_char[15:8], entry_value[31:16],
    // char_value[39:32], gap_position[47:40]
    input  logic [47:0] s_axis_tdata,
    // mode[2:0], seq_select[3]
    input  logic [7:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // score[31:0]
    output logic [31:0] m_axis_tdata,
    // status[1:0]
    output logic [7:0]  m_axis_tuser,
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_RUN, S_DRAIN, S_BEST, S_FINISH
    } t_state;

    // Request fields.
    logic [7:0]          w_row, w_col, w_char;
    logic signed [15:0]  w_entry;
    logic signed [7:0]   w_gap;
    logic [2:0]          w_mode;
    logic                w_sel;
    logic                w_acc;

    assign w_row   = s_axis_tdata[7:0];
    assign w_col   = s_axis_tdata[15:8];
    assign w_entry = s_axis_tdata[31:16];
    assign w_char  = s_axis_tdata[39:32];
    assign w_gap   = s_axis_tdata[47:40];
    assign w_mode  = s_axis_tuser[2:0];
    assign w_sel   = s_axis_tuser[3];

    // Configuration registers.
    logic signed [15:0] r_gap_pen;
    logic [6:0]         r_v_off;
    logic [6:0]         r_j_off;
    logic signed [15:0] r_scale;
    logic               r_use_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_pen <= '0;
            r_v_off   <= '0;
            r_j_off   <= '0;
            r_scale   <= ONE_Q88;
            r_use_mat <= 1'b0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_GAP_PEN: r_gap_pen <= i_cfg_wdata;
                CFG_V_OFF:   r_v_off   <= i_cfg_wdata[6:0];
                CFG_J_OFF:   r_j_off   <= i_cfg_wdata[6:0];
                CFG_SCALE:   r_scale   <= i_cfg_wdata;
                CFG_USE_MAT: r_use_mat <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Control state.
    t_state                  r_state;
    logic [LEN_W-1:0]        r_len1, r_len2;
    logic [GCNT_W-1:0]       r_gap_cnt;
    logic                    r_ovf;
    logic signed [7:0]       r_gap_list [MAX_GAPS];
    logic [GIDX_W-1:0]       r_k;
    logic [6:0]              r_end;
    logic [6:0]              r_colx;
    logic [7:0]              r_g0, r_g1;
    logic [6:0]              r_glen;
    logic                    r_shift1;
    logic [1:0]              r_drain;
    logic signed [ACC_W-1:0] r_acc, r_best;
    t_res_sel                r_rsel;
    t_status                 r_rstat;
    t_col_req                r_col1;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // Window bounds at compute time.
    logic [LEN_W-1:0]  w_longer;
    logic signed [9:0] w_end_s;
    logic signed [9:0] w_start_s;
    assign w_longer  = (r_len1 > r_len2) ? r_len1 : r_len2;
    assign w_end_s   = 10'(w_longer) - 10'(r_j_off);
    assign w_start_s = 10'(r_v_off);

    // Gap geometry for the current position.
    logic signed [9:0] n1, n2, m, glen, gp, p, pe, g0, g1, en;
    always_comb begin
        n1   = 10'(r_len1);
        n2   = 10'(r_len2);
        m    = (n1 < n2) ? n1 : n2;
        glen = (n1 < n2) ? (n2 - n1) : (n1 - n2);
        gp   = 10'(r_gap_list[r_k]);
        if (gp >= 0) begin
            p = (gp > m) ? m : gp;
        end else begin
            p = ((m + gp) < 0) ? 10'sd0 : (m + gp);
        end
        pe = p + glen;
        en = 10'(r_end);
        g0 = (w_start_s > p) ? w_start_s : p;
        g1 = (en < pe) ? en : pe;
    end

    // Column issue: region of the current column and memory addresses.
    logic       w_issue, w_aligned, w_gapcol, w_shifted;
    logic [6:0] w_sh;
    logic [ADDR_W-1:0] w_addr1, w_addr2;
    always_comb begin
        w_issue   = (r_state == S_RUN);
        w_aligned = (8'(r_colx) < r_g0);
        w_gapcol  = !w_aligned && (8'(r_colx) < r_g1);
        w_shifted = !w_aligned && !w_gapcol;
        w_sh      = r_colx - r_glen;
        w_addr1   = (w_shifted && r_shift1)  ? w_sh[ADDR_W-1:0] : r_colx[ADDR_W-1:0];
        w_addr2   = (w_shifted && !r_shift1) ? w_sh[ADDR_W-1:0] : r_colx[ADDR_W-1:0];
    end

    // Sequence memories.
    logic [7:0] r_seq1 [MAX_LEN];
    logic [7:0] r_seq2 [MAX_LEN];
    logic [7:0] r_rd1, r_rd2;
    logic       w_wr1, w_wr2;

    assign w_wr1 = w_acc && (w_mode == MODE_APP_CHAR) && !w_sel
                   && (r_len1 < LEN_W'(MAX_LEN));
    assign w_wr2 = w_acc && (w_mode == MODE_APP_CHAR) && w_sel
                   && (r_len2 < LEN_W'(MAX_LEN));

    always_ff @(posedge i_clk) begin
        if (w_wr1) begin
            r_seq1[r_len1[ADDR_W-1:0]] <= w_char;
        end
        if (w_wr2) begin
            r_seq2[r_len2[ADDR_W-1:0]] <= w_char;
        end
        r_rd1 <= r_seq1[w_addr1];
        r_rd2 <= r_seq2[w_addr2];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (w_mode == MODE_APP_GAP) && (r_gap_cnt < GCNT_W'(MAX_GAPS))) begin
            r_gap_list[r_gap_cnt[GIDX_W-1:0]] <= w_gap;
        end
    end

    // Table and cost.
    logic               w_cost_valid;
    logic signed [15:0] w_cost;

    gsps_table u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (w_acc && (w_mode == MODE_TABLE_WR)),
        .i_wr_addr     ({w_row, w_col}),
        .i_wr_data     (w_entry),
        .i_col         (r_col1),
        .i_char_a      (r_rd1),
        .i_char_b      (r_rd2),
        .i_use_matrix  (r_use_mat),
        .i_gap_penalty (r_gap_pen),
        .o_cost_valid  (w_cost_valid),
        .o_cost        (w_cost)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_SETUP) begin
            r_acc <= '0;
        end else if (w_cost_valid) begin
            r_acc <= r_acc + ACC_W'(w_cost);
        end
    end

    // Output stage.
    t_res_req w_req;
    logic     w_free;

    always_comb begin
        w_req.go     = (r_state == S_FINISH) && w_free;
        w_req.sel    = r_rsel;
        w_req.status = r_ovf ? ST_OVF : r_rstat;
        w_req.best   = r_best;
    end

    gsps_score_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (w_req),
        .i_scale       (r_scale),
        .o_free        (w_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len1    <= '0;
            r_len2    <= '0;
            r_gap_cnt <= '0;
            r_ovf     <= 1'b0;
            r_col1    <= '0;
            r_k       <= '0;
            r_drain   <= '0;
            r_rsel    <= SEL_SCALED;
            r_rstat   <= ST_OK;
        end else begin
            r_col1.valid  <= w_issue;
            r_col1.is_gap <= w_gapcol;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (w_mode)
                            MODE_CLEAR: begin
                                r_len1    <= '0;
                                r_len2    <= '0;
                                r_gap_cnt <= '0;
                                r_ovf     <= 1'b0;
                            end
                            MODE_APP_CHAR: begin
                                if (w_wr1) begin
                                    r_len1 <= r_len1 + 1'b1;
                                end else if (w_wr2) begin
                                    r_len2 <= r_len2 + 1'b1;
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            MODE_APP_GAP: begin
                                if (r_gap_cnt < GCNT_W'(MAX_GAPS)) begin
                                    r_gap_cnt <= r_gap_cnt + 1'b1;
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            MODE_COMPUTE: begin
                                r_end <= w_end_s[6:0];
                                r_k   <= '0;
                                if (w_end_s <= w_start_s) begin
                                    r_rsel  <= SEL_ZERO;
                                    r_rstat <= ST_EMPTY;
                                    r_state <= S_FINISH;
                                end else if (r_gap_cnt == '0) begin
                                    r_rsel  <= SEL_MIN;
                                    r_rstat <= ST_NOGAP;
                                    r_state <= S_FINISH;
                                end else begin
                                    r_rsel  <= SEL_SCALED;
                                    r_rstat <= ST_OK;
                                    r_state <= S_SETUP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SETUP: begin
                    r_g0     <= g0[7:0];
                    r_g1     <= g1[7:0];
                    r_glen   <= glen[6:0];
                    r_shift1 <= (n1 < n2);
                    r_colx   <= r_v_off;
                    r_state  <= S_RUN;
                end
                S_RUN: begin
                    r_colx <= r_colx + 1'b1;
                    if (r_colx == r_end - 1'b1) begin
                        r_drain <= '0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 1'b1;
                    if (r_drain == 2'd1) begin
                        r_state <= S_BEST;
                    end
                end
                S_BEST: begin
                    if (r_k == '0 || r_acc > r_best) begin
                        r_best <= r_acc;
                    end
                    if (GCNT_W'(r_k) + 1'b1 == r_gap_cnt) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_SETUP;
                    end
                end
                S_FINISH: begin
                    if (w_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cost_only_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cost_valid |-> (r_state == S_DRAIN || r_state == S_RUN))
        else $error("cost arrived outside a column walk");
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_colx < 7'(MAX_LEN)))
        else $error("column index beyond sequence memory");
    a_gap_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap_cnt <= GCNT_W'(MAX_GAPS))
        else $error("gap count beyond capacity");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.go |=> (r_state == S_IDLE))
        else $error("sequencer stayed busy after issuing a result");
`endif

endmodule
